@@ rtl/ula_pkg.sv @@
// Package for the ULA video timing and DRAM sequencer.
// Holds payload structs, the tick descriptor passed front to back, and constants.
// No dependencies.
package ula_pkg;

    localparam int DEF_LAST_COLUMN = 447;
    localparam int DEF_LAST_LINE   = 311;
    localparam int CNT_W           = 9;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [12:0] ATTR_BASE  = 13'h1800;
    localparam logic [8:0]  VSYNC_ON   = 9'd248;
    localparam logic [8:0]  VSYNC_OFF  = 9'd252;
    localparam logic [8:0]  PIX_FIRST  = 9'd256;
    localparam logic [8:0]  PIX_END    = 9'd288;
    localparam logic [8:0]  CLEAR_COL  = 9'd319;
    localparam logic [8:0]  INT_END    = 9'd32;
    localparam logic [3:0]  PH_ATTR    = 4'h1;
    localparam logic [3:0]  PH_BITMAP  = 4'hE;
    localparam logic [3:0]  PH_LATCH_A = 4'h7;
    localparam logic [3:0]  PH_LATCH_B = 4'hB;

    typedef struct packed {
        logic [7:0] data_bus;
        logic       mreq_low;
        logic       write_low;
        logic       addr_bit14;
        logic       addr_bit15;
    } in_item_t;

    typedef struct packed {
        logic       rom_select_low;
        logic [6:0] dram_address;
        logic       ras_low;
        logic       cas_low;
        logic       we_low;
        logic       interrupt_low;
        logic       contention;
        logic       pixel_valid;
        logic [3:0] pixel_colour;
        logic [7:0] pixel_position;
        logic       last;
    } out_item_t;

    // One classified tick, as handed to the back part
    typedef struct packed {
        logic       rom_select_low;
        logic [6:0] dram_address;
        logic       ras_low;
        logic       cas_low;
        logic       we_low;
        logic       interrupt_low;
        logic       contention;
        logic       cap_wr;
        logic [5:0] cap_addr;
        logic [7:0] cap_data;
        logic       clear;
        logic       pix;
        logic [4:0] group;
        logic       flash;
    } tick_t;

endpackage

@@ rtl/ula_front.sv @@
// Front part: counters, DRAM sequencing and classification of each tick.
// Depends on ula_pkg.
module ula_front #(
    parameter int LAST_COLUMN = ula_pkg::DEF_LAST_COLUMN,
    parameter int LAST_LINE   = ula_pkg::DEF_LAST_LINE
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  ula_pkg::in_item_t in_item,
    output logic              tick_valid,
    input  logic              tick_ready,
    output ula_pkg::tick_t    tick
);
    import ula_pkg::*;

    localparam logic [CNT_W-1:0] LastCol  = CNT_W'(LAST_COLUMN);
    localparam logic [CNT_W-1:0] LastLine = CNT_W'(LAST_LINE);

    logic [8:0]  hc_reg, vc_reg;
    logic        int_reg, disp_reg, vs_reg, vsp_reg;
    logic [12:0] pix_addr_reg, attr_addr_reg;
    logic [7:0]  flash_reg;

    logic        take, p3, p2, p1, p0, cpu_ram_access, cpu_phase;
    logic [3:0]  phase;

    assign full       = !tick_ready;
    assign tick_valid = push;
    assign take       = push && tick_ready;
    assign phase      = hc_reg[3:0];
    assign {p3, p2, p1, p0} = phase;
    assign cpu_ram_access = !in_item.mreq_low && !in_item.addr_bit15 && in_item.addr_bit14;
    assign cpu_phase  = !p3 && (p2 || p1 || p0);

    // Classify the tick
    always_comb
    begin
        tick = '0;
        tick.rom_select_low = in_item.addr_bit15 | in_item.addr_bit14 | in_item.mreq_low;
        tick.ras_low = 1'b1;
        tick.cas_low = 1'b1;
        tick.we_low  = 1'b1;
        if (cpu_phase)
        begin
            if (p2 && !p1)
                tick.ras_low = !cpu_ram_access;
            if (p2 && p1 && !p0)
            begin
                tick.cas_low = !cpu_ram_access;
                tick.we_low  = !(cpu_ram_access && !in_item.write_low);
            end
        end
        else if (disp_reg)
        begin
            tick.ras_low = 1'b0;
            if (!p2)
            begin
                tick.dram_address = p0 ? pix_addr_reg[6:0] : {1'b0, pix_addr_reg[12:7]};
                tick.cas_low = !(p1 && !p0);
            end
            else
            begin
                tick.dram_address = p0 ? attr_addr_reg[6:0] : {1'b0, attr_addr_reg[12:7]};
                tick.cas_low = !(p1 && p0);
            end
        end
        else if (p3 && !p2 && !p1)
        begin
            tick.dram_address = hc_reg[6:0];
            tick.ras_low = 1'b0;
        end
        tick.interrupt_low = int_reg;
        tick.contention    = disp_reg && hc_reg[3] && !hc_reg[2];
        tick.cap_wr   = disp_reg && !hc_reg[8] && (phase == PH_ATTR || phase == PH_BITMAP);
        tick.cap_addr = {phase == PH_ATTR, hc_reg[7:3]};
        tick.cap_data = in_item.data_bus;
        tick.clear    = hc_reg == CLEAR_COL;
        tick.pix      = hc_reg >= PIX_FIRST && hc_reg < PIX_END;
        tick.group    = hc_reg[4:0];
        tick.flash    = flash_reg[4];
    end

    // Advance the counters on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg        <= '0;
            vc_reg        <= '0;
            int_reg       <= 1'b1;
            disp_reg      <= 1'b1;
            vs_reg        <= 1'b1;
            vsp_reg       <= 1'b1;
            pix_addr_reg  <= '0;
            attr_addr_reg <= '0;
            flash_reg     <= '0;
        end
        else if (take)
        begin
            hc_reg <= (hc_reg == LastCol) ? '0 : hc_reg + 9'd1;
            if (hc_reg == LastCol)
                vc_reg <= (vc_reg == LastLine) ? '0 : vc_reg + 9'd1;
            if (vc_reg == VSYNC_ON && hc_reg == '0)
                int_reg <= 1'b0;
            if (vc_reg == VSYNC_ON && hc_reg == INT_END)
                int_reg <= 1'b1;
            if (vsp_reg && !vs_reg)
                flash_reg <= flash_reg + 8'd1;
            vsp_reg <= vs_reg;
            if (vc_reg == VSYNC_OFF)
                vs_reg <= 1'b1;
            else if (vc_reg == VSYNC_ON)
                vs_reg <= 1'b0;
            disp_reg <= !((vc_reg[7] && vc_reg[6]) || vc_reg[8] || hc_reg[8]);
            if (disp_reg && (phase == PH_LATCH_A || phase == PH_LATCH_B))
            begin
                pix_addr_reg  <= {vc_reg[7:6], vc_reg[2:0], vc_reg[5:3], hc_reg[7:3]};
                attr_addr_reg <= ATTR_BASE | {3'b000, vc_reg[7:6], vc_reg[5:3], hc_reg[7:3]};
            end
        end
    end
endmodule

@@ rtl/ula_queue.sv @@
// Short queue of classified ticks between front and back parts.
// Depends on ula_pkg.
module ula_queue #(
    parameter int DEPTH = ula_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  ula_pkg::tick_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output ula_pkg::tick_t rd_data
);
    import ula_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    tick_t             mem_reg [DEPTH];
    logic [AW-1:0]     wp_reg, rp_reg;
    logic [AW:0]       cnt_reg;
    logic              wr, rd;

    assign wr_ready = cnt_reg != (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

@@ rtl/ula_back.sv @@
// Back part: capture store, pixel expansion and result output register.
// Depends on ula_pkg.
module ula_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick_valid,
    output logic               tick_ready,
    input  ula_pkg::tick_t     tick,
    output logic               empty,
    input  logic               pop,
    output ula_pkg::out_item_t out_item
);
    import ula_pkg::*;

    logic [7:0]  store_reg [64];
    logic [63:0] wvalid_reg;
    logic [7:0]  bitmap_reg, attr_reg;
    tick_t       cur_reg;
    logic        busy_reg;
    logic [2:0]  k_reg;
    logic        ovalid_reg;
    out_item_t   out_reg;
    logic        slot_free, start, emit, colour_bit;
    logic [5:0]  bm_idx, at_idx;

    assign empty      = !ovalid_reg;
    assign out_item   = out_reg;
    assign slot_free  = !ovalid_reg || pop;
    assign tick_ready = !busy_reg;
    assign start      = tick_valid && !busy_reg;
    assign emit       = busy_reg && slot_free;
    assign bm_idx     = {1'b0, tick.group};
    assign at_idx     = {1'b1, tick.group};
    assign colour_bit = bitmap_reg[3'd7 - k_reg] ^ (attr_reg[7] & cur_reg.flash);

    // Capture store writes, and read of the group pair for each accepted tick
    always_ff @(posedge clk)
    begin
        if (start && tick.cap_wr)
            store_reg[tick.cap_addr] <= tick.cap_data;
        if (start)
        begin
            bitmap_reg <= wvalid_reg[bm_idx] ? store_reg[bm_idx] : 8'd0;
            attr_reg   <= wvalid_reg[at_idx] ? store_reg[at_idx] : 8'd0;
        end
        if (start)
            cur_reg <= tick;
    end

    // Track written entries; drop all at the clear column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wvalid_reg <= '0;
        else if (start)
        begin
            if (tick.clear)
                wvalid_reg <= '0;
            else if (tick.cap_wr)
                wvalid_reg[tick.cap_addr] <= 1'b1;
        end
    end

    // Sequence results of one tick into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            k_reg      <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (pop && ovalid_reg)
                ovalid_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (emit)
            begin
                ovalid_reg <= 1'b1;
                k_reg      <= k_reg + 3'd1;
                if (!cur_reg.pix || k_reg == 3'd7)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.rom_select_low <= cur_reg.rom_select_low;
            out_reg.dram_address   <= cur_reg.dram_address;
            out_reg.ras_low        <= cur_reg.ras_low;
            out_reg.cas_low        <= cur_reg.cas_low;
            out_reg.we_low         <= cur_reg.we_low;
            out_reg.interrupt_low  <= cur_reg.interrupt_low;
            out_reg.contention     <= cur_reg.contention;
            out_reg.pixel_valid    <= cur_reg.pix;
            out_reg.pixel_colour   <= cur_reg.pix ?
                {attr_reg[6], colour_bit ? attr_reg[2:0] : attr_reg[5:3]} : 4'd0;
            out_reg.pixel_position <= cur_reg.pix ? {cur_reg.group, k_reg} : 8'd0;
            out_reg.last           <= !cur_reg.pix || k_reg == 3'd7;
        end
    end
endmodule

@@ rtl/ula_video_timing_dram_sequencer.sv @@
// Top level of the ULA video timing and DRAM sequencer.
// Depends on ula_pkg, ula_front, ula_queue and ula_back.
//
//  channel   handshake     payload
//  input     push / full   in_item  (ula_pkg::in_item_t)
//  result    empty / pop   out_item (ula_pkg::out_item_t)
//
// A tick is classified in the front and queued. The back takes one tick,
// registers its group pair from the capture store, then emits one result
// per cycle while its single-result output register is free: one for an
// ordinary tick, eight for a pixel tick (columns 256 to 287). Reset clears
// counters and store valid bits at once. Each side stalls on its own.
module ula_video_timing_dram_sequencer #(
    parameter int LAST_COLUMN = ula_pkg::DEF_LAST_COLUMN,
    parameter int LAST_LINE   = ula_pkg::DEF_LAST_LINE
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ula_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output ula_pkg::out_item_t out_item
);
    import ula_pkg::*;

    tick_t f_tick, b_tick;
    logic  f_valid, f_ready, b_valid, b_ready;

    ula_front #(.LAST_COLUMN(LAST_COLUMN), .LAST_LINE(LAST_LINE)) u_front (
        .clk, .rst_n, .push, .full, .in_item,
        .tick_valid(f_valid), .tick_ready(f_ready), .tick(f_tick)
    );

    ula_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_tick),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_tick)
    );

    ula_back u_back (
        .clk, .rst_n,
        .tick_valid(b_valid), .tick_ready(b_ready), .tick(b_tick),
        .empty, .pop, .out_item
    );
endmodule
